// ===== src/bpa_pkg.sv =====
// Shared constants, register indexes and a helper function for the bitmap page allocator.
// No dependencies; the top level and the testbench import this package.
package bpa_pkg;

	localparam int MAP_WORDS = 64;
	localparam int WORD_W    = 64;
	localparam int IDX_W     = $clog2(MAP_WORDS);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int PAGE_W    = IDX_W + BIT_W;
	localparam int ADDR_W    = 48;
	localparam int SHIFT_W   = 5;
	localparam int CNT_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int SMALL_MAX = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd2;

	localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
	localparam logic [CNT_W-1:0]   TOTAL_RST = 13'd4096;
	localparam logic [CNT_W-1:0]   MAP_PAGES = CNT_W'(MAP_WORDS * WORD_W);

	localparam logic [WORD_W-1:0] FULL_WORD = {WORD_W{1'b1}};

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Pages of word w at or above the managed total read as used.
	function automatic logic [WORD_W-1:0] reserved_bits(input logic [IDX_W-1:0] w,
			input logic [CNT_W-1:0] total_in);
		logic [CNT_W:0] total;
		logic [CNT_W:0] lo;
		logic [CNT_W:0] rel;
		total = (total_in > MAP_PAGES) ? {1'b0, MAP_PAGES} : {1'b0, total_in};
		lo    = (CNT_W+1)'({w, {BIT_W{1'b0}}});
		rel   = total - lo;
		if (total >= lo + (CNT_W+1)'(WORD_W))
			reserved_bits = '0;
		else if (total <= lo)
			reserved_bits = FULL_WORD;
		else
			reserved_bits = FULL_WORD << rel[BIT_W-1:0];
	endfunction

endpackage

// ===== src/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page allocator: sequencer, config registers, result beat.
// Depends on bpa_pkg and bpa_ram.
//
// The block keeps a 64 x 64-bit page bitmap in one RAM (registered read) and serves one
// request at a time; in_ready is high only while the sequencer is idle. A small allocation
// (1 to 31 pages) visits words from word 0, each through read, run-mask build, and match
// and mark. A large allocation (32 pages or more) visits words, reading and checking each
// while counting wholly free words, then writes the covered words full at one word a cycle.
// An allocation then passes through the address add (or the failure code) and the result
// beat. A zero-count or oversized allocation goes straight to the failure code. A free does
// the address arithmetic (subtract, then shift), then reads and clear-writes each touched
// word, then gives the result beat; a free that touches no word skips the reads. Reset
// clears the bitmap at once through per-word valid bits, so no clearing pass runs.
// Configuration writes are registered and may come at any time the block is idle; a
// finished result waits in an output register and the next request is accepted meanwhile.
module bitmap_page_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpa_pkg::ADDR_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [bpa_pkg::CNT_W-1:0]          page_count,
	input  logic [bpa_pkg::ADDR_W-1:0]         address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bpa_pkg::ADDR_W-1:0]         result_address,
	output logic                               ok
);
	import bpa_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_F_SUB = 4'd1;
	localparam logic [3:0] ST_F_SHF = 4'd2;
	localparam logic [3:0] ST_F_RD  = 4'd3;
	localparam logic [3:0] ST_F_WR  = 4'd4;
	localparam logic [3:0] ST_S_RD  = 4'd5;
	localparam logic [3:0] ST_S_POW = 4'd6;
	localparam logic [3:0] ST_S_CMB = 4'd7;
	localparam logic [3:0] ST_L_RD  = 4'd8;
	localparam logic [3:0] ST_L_CHK = 4'd9;
	localparam logic [3:0] ST_L_FIL = 4'd10;
	localparam logic [3:0] ST_ADDR  = 4'd11;
	localparam logic [3:0] ST_FAIL  = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	localparam logic [IDX_W-1:0] LAST_W = IDX_W'(MAP_WORDS - 1);

	// configuration
	logic [ADDR_W-1:0]  base_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [CNT_W-1:0]   total_q;

	// request and sequencer state
	logic [3:0]         state_q;
	logic               act_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  diff_q;
	logic [PAGE_W-1:0]  first_q;
	logic [CNT_W:0]     end_q;
	logic [IDX_W-1:0]   wq_q;
	logic [IDX_W-1:0]   fill_q;
	logic [IDX_W:0]     run_q;
	logic [CNT_W-IDX_W:0] words_q;
	logic [PAGE_W-1:0]  page_q;
	logic [WORD_W-1:0]  word_q;
	logic [WORD_W-1:0]  p1_q, p2_q, p4_q, p8_q, p16_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               res_ok_q;

	// bitmap valid bits: an unwritten word reads as all free
	logic [MAP_WORDS-1:0] vld_q;
	logic                 rd_vld_q;

	// result beat register
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_ok_q;

	// RAM port
	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;

	bpa_ram #(.W(WORD_W), .DEPTH(MAP_WORDS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (wq_q),
		.rdata (ram_rdata)
	);

	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] used;
	logic [WORD_W-1:0] free_v;
	assign rd_word = ram_rdata & {WORD_W{rd_vld_q}};
	assign used    = rd_word | reserved_bits(wq_q, total_q);
	assign free_v  = ~used;

	// Words a large request covers, rounded up; wide enough for the largest count.
	logic [CNT_W:0] words_need;
	assign words_need = ((CNT_W+1)'(page_count) + (CNT_W+1)'(WORD_W - 1)) >> BIT_W;

	// Small run: combine the power-of-two run masks along the bits of the count.
	logic [BIT_W-1:0]  n_small;
	logic [WORD_W-1:0] acc;
	logic              hit;
	logic [BIT_W-1:0]  hit_pos;
	logic [WORD_W-1:0] run_mask;
	assign n_small = BIT_W'(cnt_q[BIT_W-2:0]);

	always_comb begin
		logic [BIT_W-1:0] off;
		acc = FULL_WORD;
		off = '0;
		if (n_small[4]) begin
			acc = acc & (p16_q >> off);
			off = off + BIT_W'(16);
		end
		if (n_small[3]) begin
			acc = acc & (p8_q >> off);
			off = off + BIT_W'(8);
		end
		if (n_small[2]) begin
			acc = acc & (p4_q >> off);
			off = off + BIT_W'(4);
		end
		if (n_small[1]) begin
			acc = acc & (p2_q >> off);
			off = off + BIT_W'(2);
		end
		if (n_small[0])
			acc = acc & (p1_q >> off);
		hit     = |acc;
		hit_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (acc[i])
				hit_pos = BIT_W'(i);
		end
		run_mask = ((WORD_W'(1) << n_small) - WORD_W'(1)) << hit_pos;
	end

	// Free: bits of the current word that fall inside [first, end).
	logic [CNT_W:0]    wlo;
	logic [CNT_W:0]    end_rel;
	logic [WORD_W-1:0] clr_mask;
	logic              free_last;
	always_comb begin
		logic [WORD_W-1:0] ge_m;
		logic [WORD_W-1:0] lt_m;
		wlo     = (CNT_W+1)'({wq_q, {BIT_W{1'b0}}});
		end_rel = end_q - wlo;
		ge_m    = (first_q[PAGE_W-1:BIT_W] == wq_q) ? (FULL_WORD << first_q[BIT_W-1:0])
			: FULL_WORD;
		lt_m    = (end_rel >= (CNT_W+1)'(WORD_W)) ? FULL_WORD
			: ~(FULL_WORD << end_rel[BIT_W-1:0]);
		clr_mask  = ge_m & lt_m;
		free_last = (wq_q == LAST_W) || (end_q <= wlo + (CNT_W+1)'(WORD_W));
	end

	logic [ADDR_W-1:0] fshift;
	assign fshift = diff_q >> shift_q;

	logic large_hit;
	assign large_hit = (used == '0) && ((run_q + 1'b1) == (IDX_W+1)'(words_q));

	// RAM control
	always_comb begin
		ram_re    = (state_q == ST_F_RD) || (state_q == ST_S_RD) || (state_q == ST_L_RD);
		ram_we    = 1'b0;
		ram_waddr = wq_q;
		ram_wdata = rd_word & ~clr_mask;
		case (state_q)
			ST_F_WR:  ram_we = 1'b1;
			ST_S_CMB: begin
				ram_we    = hit;
				ram_wdata = word_q | run_mask;
			end
			ST_L_FIL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q;
				ram_wdata = FULL_WORD;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			shift_q <= SHIFT_RST;
			total_q <= TOTAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				REG_TOTAL: total_q <= cfg_data[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_re)
				rd_vld_q <= vld_q[wq_q];
			if (ram_we)
				vld_q[ram_waddr] <= 1'b1;
			// load a finished beat once the register is free, else drop the sent one
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						wq_q  <= '0;
						run_q <= '0;
						if (action == ACT_FREE)
							state_q <= ST_F_SUB;
						else if (page_count == '0)
							state_q <= ST_FAIL;
						else if (page_count < CNT_W'(SMALL_MAX))
							state_q <= ST_S_RD;
						else if (words_need > (CNT_W+1)'(MAP_WORDS))
							state_q <= ST_FAIL;
						else
							state_q <= ST_L_RD;
					end
				end
				ST_F_SUB: state_q <= ST_F_SHF;
				ST_F_SHF: begin
					wq_q <= fshift[PAGE_W-1:BIT_W];
					if ((|fshift[ADDR_W-1:PAGE_W]) || (cnt_q == '0)) begin
						res_ok_q   <= 1'b1;
						res_addr_q <= '0;
						state_q    <= ST_DONE;
					end else
						state_q <= ST_F_RD;
				end
				ST_F_RD: state_q <= ST_F_WR;
				ST_F_WR: begin
					if (free_last) begin
						res_ok_q   <= 1'b1;
						res_addr_q <= '0;
						state_q    <= ST_DONE;
					end else begin
						wq_q    <= wq_q + 1'b1;
						state_q <= ST_F_RD;
					end
				end
				ST_S_RD:  state_q <= ST_S_POW;
				ST_S_POW: state_q <= ST_S_CMB;
				ST_S_CMB: begin
					if (hit) begin
						page_q  <= {wq_q, hit_pos};
						state_q <= ST_ADDR;
					end else if (wq_q == LAST_W)
						state_q <= ST_FAIL;
					else begin
						wq_q    <= wq_q + 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_L_RD: state_q <= ST_L_CHK;
				ST_L_CHK: begin
					if (large_hit) begin
						fill_q  <= wq_q - words_q[IDX_W-1:0] + 1'b1;
						page_q  <= {wq_q - words_q[IDX_W-1:0] + 1'b1, {BIT_W{1'b0}}};
						state_q <= ST_L_FIL;
					end else begin
						run_q <= (used == '0) ? run_q + 1'b1 : '0;
						if (wq_q == LAST_W)
							state_q <= ST_FAIL;
						else begin
							wq_q    <= wq_q + 1'b1;
							state_q <= ST_L_RD;
						end
					end
				end
				ST_L_FIL: begin
					if (fill_q == wq_q)
						state_q <= ST_ADDR;
					else
						fill_q <= fill_q + 1'b1;
				end
				ST_ADDR: begin
					res_ok_q   <= 1'b1;
					res_addr_q <= base_q + (ADDR_W'(page_q) << shift_q);
					state_q    <= ST_DONE;
				end
				ST_FAIL: begin
					res_ok_q   <= 1'b0;
					res_addr_q <= '0;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the previous beat has left the output register
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q  <= action;
			cnt_q  <= page_count;
			addr_q <= address;
			words_q <= (CNT_W-IDX_W+1)'(words_need);
		end
		if (state_q == ST_F_SUB)
			diff_q <= addr_q - base_q;
		if (state_q == ST_F_SHF) begin
			first_q <= fshift[PAGE_W-1:0];
			end_q   <= (CNT_W+1)'(fshift[PAGE_W-1:0]) + (CNT_W+1)'(cnt_q);
		end
		if (state_q == ST_S_POW) begin
			word_q <= rd_word;
			p1_q   <= free_v;
			p2_q   <= free_v & (free_v >> 1);
			p4_q   <= (free_v & (free_v >> 1)) & ((free_v & (free_v >> 1)) >> 2);
			p8_q   <= free_v & (free_v >> 1) & (free_v >> 2) & (free_v >> 3)
				& (free_v >> 4) & (free_v >> 5) & (free_v >> 6) & (free_v >> 7);
		end
		if (state_q == ST_S_POW)
			p16_q <= (free_v & (free_v >> 1) & (free_v >> 2) & (free_v >> 3)
				& (free_v >> 4) & (free_v >> 5) & (free_v >> 6) & (free_v >> 7))
				& ((free_v & (free_v >> 1) & (free_v >> 2) & (free_v >> 3)
				& (free_v >> 4) & (free_v >> 5) & (free_v >> 6) & (free_v >> 7)) >> 8);
		if ((state_q == ST_DONE) && out_free) begin
			out_addr_q <= res_addr_q;
			out_ok_q   <= res_ok_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign ok             = out_ok_q;

	// a failed beat carries address zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ok_q) |-> (out_addr_q == '0))
		else $error("failed allocation beat with nonzero address");

	// the map is never written while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("bitmap write while idle");

	// an accepted beat starts the sequencer
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted request did not start the sequencer");

	// a free beat always reports success
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && (act_q == ACT_FREE)) |-> res_ok_q)
		else $error("free did not report success");

endmodule

// ===== src/bpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
	parameter int W     = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== verif/bitmap_page_allocator_test.sv =====
// Self-checking testbench for the first-fit bitmap page allocator.
// Depends on bpa_pkg and bitmap_page_allocator; holds its own bitmap predictor.
module bitmap_page_allocator_test;
	import bpa_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              ok;
	} grant_t;

	// Predictor of the allocator plus the queue of grants still owed by the block.
	class grant_board;
		logic [WORD_W-1:0] pages [MAP_WORDS];
		logic [ADDR_W-1:0] base;
		logic [SHIFT_W-1:0] shift;
		logic [CNT_W-1:0]  total;
		grant_t            owed [$];
		int                errors;

		function void clear();
			foreach (pages[w]) pages[w] = '0;
			base = '0; shift = SHIFT_RST; total = TOTAL_RST; errors = 0;
		endfunction

		function logic [WORD_W-1:0] held(int w);
			int t;
			int lo;
			t = (total > MAP_WORDS * 64) ? MAP_WORDS * 64 : total;
			lo = w * 64;
			if (t >= lo + 64) return pages[w];
			if (t <= lo) return FULL_WORD;
			return pages[w] | (FULL_WORD << (t - lo));
		endfunction

		function logic [ADDR_W-1:0] page_to_addr(int p);
			logic [63:0] sh;
			sh = 64'(p) << shift;
			return base + sh[ADDR_W-1:0];
		endfunction

		// Note an accepted request: update the map and queue the grant it causes.
		function void note_request(logic act, logic [CNT_W-1:0] n, logic [ADDR_W-1:0] a);
			grant_t g;
			logic [WORD_W-1:0] run;
			logic [ADDR_W-1:0] off;
			longint first;
			int words, s, k;
			bit hit;
			g = '0;
			if (act == ACT_FREE) begin
				off = a - base;
				first = longint'(off >> shift);
				for (int i = 0; i < n; i++) begin
					if (first + i >= MAP_WORDS * 64) break;
					pages[(first + i) / 64][(first + i) % 64] = 1'b0;
				end
				g.ok = 1'b1;
			end else if (n == 0) begin
				g.ok = 1'b0;
			end else if (n < SMALL_MAX) begin
				run = (64'd1 << n) - 1;
				hit = 0;
				for (int w = 0; w < MAP_WORDS && !hit; w++)
					for (int j = 0; j + n <= 64 && !hit; j++)
						if ((held(w) & (run << j)) == 0) begin
							pages[w] |= run << j;
							g.addr = page_to_addr(w * 64 + j);
							hit = 1;
						end
				g.ok = hit;
			end else begin
				words = (n + 63) / 64;
				hit = 0;
				for (s = 0; s + words <= MAP_WORDS && !hit; s++) begin
					for (k = s; k < s + words; k++)
						if (held(k) != 0) break;
					if (k == s + words) begin
						for (k = s; k < s + words; k++) pages[k] = FULL_WORD;
						g.addr = page_to_addr(s * 64);
						hit = 1;
					end
				end
				g.ok = hit;
			end
			owed.push_back(g);
		endfunction

		// Compare one result beat against the oldest owed grant.
		function void check_grant(logic [ADDR_W-1:0] a, logic k);
			grant_t g;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result addr=%h ok=%b", $time, a, k);
				errors++;
				return;
			end
			g = owed.pop_front();
			if (a !== g.addr) begin
				$display("%0t: result_address expected %h actual %h", $time, g.addr, a);
				errors++;
			end
			if (k !== g.ok) begin
				$display("%0t: ok expected %b actual %b", $time, g.ok, k);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_ready;
	logic action = 0;
	logic [CNT_W-1:0] page_count = '0;
	logic [ADDR_W-1:0] address = '0;
	logic out_valid, out_ready = 0, ok;
	logic [ADDR_W-1:0] result_address;

	grant_board board;
	longint cycles = 0;
	bit hold_off = 0;  // receiver holds off while the sender keeps offering

	bitmap_page_allocator u_dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Watchdog sized for ~1550 items plus long stalls, several times over; it prints FAIL and stops.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3_000_000) begin
			$display("FAIL");
			$finish;
		end
	end

	// Check result beats at the rising edge.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) board.check_grant(result_address, ok);

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: random stalls, driven at the falling edge; a long hold-off when asked.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (600) @(negedge clk);
				hold_off = 0;
			end
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g > 0) begin
				out_ready <= 0;
				repeat (g - 1) @(negedge clk);
			end else
				out_ready <= 1;
		end
	end

	// Offer one request beat and hold it until accepted; drop valid only over a gap.
	task automatic send_request(logic act, logic [CNT_W-1:0] n, logic [ADDR_W-1:0] a,
			bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1; action <= act; page_count <= n; address <= a;
		do @(posedge clk); while (!in_ready);
		board.note_request(act, n, a);
		@(negedge clk);
	endtask

	// Write a register while the block is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_BASE:  board.base  = v;
			REG_SHIFT: board.shift = v[SHIFT_W-1:0];
			REG_TOTAL: board.total = v[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.owed.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	// Address of a given page in the current setting, used to aim frees at the map.
	function automatic logic [ADDR_W-1:0] page_address(int p);
		return board.page_to_addr(p);
	endfunction

	task automatic random_phase(int items);
		int r, n;
		logic act;
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			act = (r < 45) ? ACT_FREE : ACT_ALLOC;
			if ($urandom_range(0, 9) < 8) n = $urandom_range(1, 31);
			else if ($urandom_range(0, 9) < 8) n = $urandom_range(32, 400);
			else n = $urandom_range(0, 8191);
			if (act == ACT_FREE && $urandom_range(0, 9) < 8)
				a = page_address($urandom_range(0, 4200));
			else
				a = ADDR_W'({$urandom, $urandom});
			if (i == items / 2 && items > 100) hold_off = 1;
			send_request(act, n[CNT_W-1:0], a, 1);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: count extremes, both actions, large runs, wrap, free off the map.
		send_request(ACT_ALLOC, 0, '0, 0);
		send_request(ACT_ALLOC, 1, '0, 0);
		send_request(ACT_ALLOC, 31, '0, 0);
		send_request(ACT_ALLOC, 32, '0, 0);
		send_request(ACT_ALLOC, 64, '0, 0);
		send_request(ACT_ALLOC, 65, '0, 0);
		send_request(ACT_ALLOC, 4096, '0, 0);
		send_request(ACT_ALLOC, 8191, '1, 0);
		send_request(ACT_FREE, 0, '0, 0);
		send_request(ACT_FREE, 8191, '0, 0);
		send_request(ACT_ALLOC, 4096, '0, 0);
		send_request(ACT_FREE, 5, 48'hFFFF_FFFF_FFFF, 0);
		send_request(ACT_FREE, 4096, '0, 0);
		drain();
		write_reg(REG_BASE, 48'hFFFF_FFFF_F000);
		write_reg(REG_SHIFT, 30);
		write_reg(REG_TOTAL, 0);
		send_request(ACT_ALLOC, 1, '0, 0);
		drain();
		write_reg(REG_TOTAL, 8191);
		send_request(ACT_ALLOC, 3, '0, 0);
		send_request(ACT_ALLOC, 100, '0, 0);
		send_request(ACT_FREE, 3, 48'hFFFF_FFFF_F000, 0);
		drain();
		write_reg(REG_TOTAL, 1);
		send_request(ACT_ALLOC, 2, '0, 0);
		send_request(ACT_ALLOC, 1, '0, 0);
		drain();
		write_reg(REG_TOTAL, 4096);
		send_request(ACT_FREE, 100, 48'hFFFF_FFFF_F000, 0);
		drain();

		// Random phases across several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_BASE, '0); write_reg(REG_SHIFT, 12);
					write_reg(REG_TOTAL, 4096); end
				1: begin write_reg(REG_BASE, '1); write_reg(REG_SHIFT, 0);
					write_reg(REG_TOTAL, $urandom_range(1, 4096)); end
				2: begin write_reg(REG_BASE, ADDR_W'({$urandom, $urandom}));
					write_reg(REG_SHIFT, 31); write_reg(REG_TOTAL, 700); end
				3: begin write_reg(REG_SHIFT, $urandom_range(0, 30));
					write_reg(REG_TOTAL, 8191); end
				4: begin write_reg(REG_TOTAL, 0); end
				default: begin write_reg(REG_BASE, 48'h1000_0000);
					write_reg(REG_SHIFT, 12); write_reg(REG_TOTAL, 3000); end
			endcase
			random_phase(ph == 4 ? 50 : 300);
			drain();
		end

		if (board.errors == 0 && board.owed.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
